>>> rtl/bkid_pkg.sv
// Shared constants, register indexes and the queue entry type of the downscaler.
`default_nettype none

package bkid_pkg;

   localparam int MAX_OUT_WIDTH = 2048;
   localparam int MAX_IN_WIDTH  = 8192;
   localparam int FRAC_BITS     = 16;

   localparam int ACC_W    = 30;
   localparam int POS_W    = ACC_W - FRAC_BITS;          // integer part of a position
   localparam int COL_W    = $clog2(MAX_IN_WIDTH);       // input column counter
   localparam int IW_W     = 14;                         // input_width register
   localparam int OW_W     = 12;                         // output_width register
   localparam int OH_W     = 14;                         // output_height register
   localparam int ROW_W    = 16;                         // input row counter
   localparam int IDX_W    = $clog2(MAX_OUT_WIDTH);      // line store address
   localparam int OCOL_W   = IDX_W + 1;                  // output column, holds the width
   localparam int COLOR_W  = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 30;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CSR_IDX_W-1:0] REG_BACKGROUND    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_WIDTH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_X        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_Y        = 3'd5;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [COLOR_W-1:0] pix;
      logic               wr;
      logic               emit;
      logic               row_end;
      logic               frame_end;
   } op_type;

   function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
      logic [ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> rtl/bkid_front.sv
// Front end: configuration registers, raster counters and per-pixel classification.
`default_nettype none

module bkid_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic [7:0]                           pixel_red,
   input  wire logic [7:0]                           pixel_green,
   input  wire logic [7:0]                           pixel_blue,
   input  wire logic                                 frame_start,
   input  wire logic                                 csr_write,
   input  wire logic [bkid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bkid_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                      push,
   output bkid_pkg::op_type                          op
);

   logic [bkid_pkg::COLOR_W-1:0] bg_ff;
   logic [bkid_pkg::IW_W-1:0]    iw_ff;
   logic [bkid_pkg::OW_W-1:0]    ow_ff;
   logic [bkid_pkg::OH_W-1:0]    oh_ff;
   logic [bkid_pkg::ACC_W-1:0]   step_x_ff;
   logic [bkid_pkg::ACC_W-1:0]   step_y_ff;

   logic [bkid_pkg::COL_W-1:0]   in_column_ff, in_column_in;
   logic [bkid_pkg::ROW_W-1:0]   in_row_ff, in_row_in;
   logic [bkid_pkg::ACC_W-1:0]   x_acc_ff, x_acc_in;
   logic [bkid_pkg::ACC_W-1:0]   y_acc_ff, y_acc_in;
   logic [bkid_pkg::OCOL_W-1:0]  out_column_ff, out_column_in;
   logic [bkid_pkg::OH_W-1:0]    out_row_ff, out_row_in;

   logic [bkid_pkg::COL_W-1:0]   col;
   logic [bkid_pkg::ROW_W-1:0]   row;
   logic [bkid_pkg::ACC_W-1:0]   x_acc, y_acc;
   logic [bkid_pkg::OCOL_W-1:0]  ocol;
   logic [bkid_pkg::OH_W-1:0]    orow;
   logic [bkid_pkg::IW_W-1:0]    iw;
   logic [bkid_pkg::OW_W-1:0]    ow;
   logic [bkid_pkg::POS_W-1:0]   rx, ry, xs, ys, dx;
   logic [bkid_pkg::ROW_W-1:0]   dy;
   logic [bkid_pkg::COLOR_W-1:0] pix;
   logic in_frame, row_active, last_row, row_last_pixel;
   logic hit, top_left, blk_end, close_blk, wr, emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff     <= 24'hFFFFFF;
         iw_ff     <= 14'd1024;
         ow_ff     <= 12'd512;
         oh_ff     <= 14'd512;
         step_x_ff <= 30'(2 << bkid_pkg::FRAC_BITS);
         step_y_ff <= 30'(2 << bkid_pkg::FRAC_BITS);
      end else if (csr_write) begin
         unique case (csr_index)
            bkid_pkg::REG_BACKGROUND:    bg_ff     <= csr_wdata[bkid_pkg::COLOR_W-1:0];
            bkid_pkg::REG_INPUT_WIDTH:   iw_ff     <= csr_wdata[bkid_pkg::IW_W-1:0];
            bkid_pkg::REG_OUTPUT_WIDTH:  ow_ff     <= csr_wdata[bkid_pkg::OW_W-1:0];
            bkid_pkg::REG_OUTPUT_HEIGHT: oh_ff     <= csr_wdata[bkid_pkg::OH_W-1:0];
            bkid_pkg::REG_STEP_X:        step_x_ff <= csr_wdata[bkid_pkg::ACC_W-1:0];
            bkid_pkg::REG_STEP_Y:        step_y_ff <= csr_wdata[bkid_pkg::ACC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // A frame start clears every counter before its own pixel is classified.
      col   = frame_start ? '0 : in_column_ff;
      row   = frame_start ? '0 : in_row_ff;
      x_acc = frame_start ? '0 : x_acc_ff;
      y_acc = frame_start ? '0 : y_acc_ff;
      ocol  = frame_start ? '0 : out_column_ff;
      orow  = frame_start ? '0 : out_row_ff;

      pix = {pixel_red, pixel_green, pixel_blue};

      if (iw_ff == '0)
         iw = 14'd1;
      else if (iw_ff > 14'(bkid_pkg::MAX_IN_WIDTH))
         iw = 14'(bkid_pkg::MAX_IN_WIDTH);
      else
         iw = iw_ff;
      ow = (ow_ff > 12'(bkid_pkg::MAX_OUT_WIDTH)) ? 12'(bkid_pkg::MAX_OUT_WIDTH) : ow_ff;

      rx = step_x_ff[bkid_pkg::ACC_W-1:bkid_pkg::FRAC_BITS];
      if (rx == '0)
         rx = 14'd1;
      ry = step_y_ff[bkid_pkg::ACC_W-1:bkid_pkg::FRAC_BITS];
      if (ry == '0)
         ry = 14'd1;
      xs = x_acc[bkid_pkg::ACC_W-1:bkid_pkg::FRAC_BITS];
      ys = y_acc[bkid_pkg::ACC_W-1:bkid_pkg::FRAC_BITS];

      dy             = row - {2'b00, ys};
      in_frame       = (orow < oh_ff) && (row >= {2'b00, ys});
      row_active     = in_frame && (dy < {2'b00, ry});
      last_row       = in_frame && (dy >= {2'b00, ry - 14'd1});
      row_last_pixel = ({1'b0, col} >= (iw - 14'd1));

      dx        = {1'b0, col} - xs;
      hit       = row_active && ({1'b0, ocol} < {1'b0, ow}) && ({1'b0, col} >= xs);
      top_left  = (row == {2'b00, ys}) && ({1'b0, col} == xs);
      blk_end   = (dx >= (rx - 14'd1)) || row_last_pixel;
      close_blk = hit && blk_end;
      wr        = hit && (top_left || (pix != bg_ff));
      emit      = close_blk && last_row;

      op.idx       = ocol[bkid_pkg::IDX_W-1:0];
      op.pix       = pix;
      op.wr        = wr;
      op.emit      = emit;
      op.row_end   = (ocol == (ow - 12'd1));
      op.frame_end = op.row_end && (orow == (oh_ff - 14'd1));
      push         = accept && (wr || emit);

      x_acc_in      = close_blk ? bkid_pkg::acc_add(x_acc, step_x_ff) : x_acc;
      out_column_in = close_blk ? ocol + 12'd1 : ocol;
      y_acc_in      = y_acc;
      out_row_in    = orow;
      in_row_in     = row;
      in_column_in  = col + 13'd1;
      if (row_last_pixel) begin
         in_column_in  = '0;
         x_acc_in      = '0;
         out_column_in = '0;
         if (last_row) begin
            out_row_in = orow + 14'd1;
            y_acc_in   = bkid_pkg::acc_add(y_acc, step_y_ff);
         end
         if (row != {bkid_pkg::ROW_W{1'b1}})
            in_row_in = row + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         x_acc_ff      <= '0;
         y_acc_ff      <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
      end else if (accept) begin
         in_column_ff  <= in_column_in;
         in_row_ff     <= in_row_in;
         x_acc_ff      <= x_acc_in;
         y_acc_ff      <= y_acc_in;
         out_column_ff <= out_column_in;
         out_row_ff    <= out_row_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/bkid_queue.sv
// Short FIFO of classified line-store operations between front and back end.
`default_nettype none

module bkid_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire bkid_pkg::op_type push_op,
   input  wire logic             pop,
   output bkid_pkg::op_type      head,
   output logic                  empty,
   output logic                  full
);

   bkid_pkg::op_type             slot_ff [bkid_pkg::QUEUE_DEPTH];
   logic [bkid_pkg::QPTR_W-1:0]  wptr_ff, rptr_ff;
   logic [bkid_pkg::QPTR_W:0]    count_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (bkid_pkg::QPTR_W+1)'(bkid_pkg::QUEUE_DEPTH));
   assign head  = slot_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wptr_ff] <= push_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push)
            wptr_ff <= wptr_ff + (bkid_pkg::QPTR_W)'(1);
         if (pop)
            rptr_ff <= rptr_ff + (bkid_pkg::QPTR_W)'(1);
         if (push && !pop)
            count_ff <= count_ff + (bkid_pkg::QPTR_W+1)'(1);
         else if (pop && !push)
            count_ff <= count_ff - (bkid_pkg::QPTR_W+1)'(1);
      end
   end

endmodule

`default_nettype wire

>>> rtl/bkid_back.sv
// Back end: per-column line store, read stage and output register.
`default_nettype none

module bkid_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bkid_pkg::op_type head,
   input  wire logic             empty,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_out_red,
   output logic [7:0]            rsp_out_green,
   output logic [7:0]            rsp_out_blue,
   output logic                  rsp_row_end,
   output logic                  rsp_frame_end
);

   logic [bkid_pkg::COLOR_W-1:0] store [bkid_pkg::MAX_OUT_WIDTH];

   logic                         s1_valid_ff;
   logic                         s1_use_pix_ff;
   logic [bkid_pkg::COLOR_W-1:0] s1_pix_ff;
   logic [bkid_pkg::COLOR_W-1:0] s1_rd_ff;
   logic                         s1_re_ff, s1_fe_ff;

   logic                         out_valid_ff;
   logic [bkid_pkg::COLOR_W-1:0] out_color_ff;
   logic                         out_re_ff, out_fe_ff;

   logic out_free, s1_adv, load_s1;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s1_adv   = s1_valid_ff && out_free;
   assign pop      = !empty && (!s1_valid_ff || s1_adv);
   assign load_s1  = pop && head.emit;

   // The written pixel wins over the stored value when the closing pixel also writes.
   always_ff @(posedge clock) begin
      if (pop && head.wr)
         store[head.idx] <= head.pix;
      if (load_s1) begin
         s1_rd_ff      <= store[head.idx];
         s1_pix_ff     <= head.pix;
         s1_use_pix_ff <= head.wr;
         s1_re_ff      <= head.row_end;
         s1_fe_ff      <= head.frame_end;
      end
      if (s1_adv) begin
         out_color_ff <= s1_use_pix_ff ? s1_pix_ff : s1_rd_ff;
         out_re_ff    <= s1_re_ff;
         out_fe_ff    <= s1_fe_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load_s1)
            s1_valid_ff <= 1'b1;
         else if (s1_adv)
            s1_valid_ff <= 1'b0;
         if (s1_adv)
            out_valid_ff <= 1'b1;
         else if (!rsp_stall)
            out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = out_color_ff[23:16];
   assign rsp_out_green = out_color_ff[15:8];
   assign rsp_out_blue  = out_color_ff[7:0];
   assign rsp_row_end   = out_re_ff;
   assign rsp_frame_end = out_fe_ff;

endmodule

`default_nettype wire

>>> rtl/background_keyed_image_downscaler.sv
// Top level of the background-keyed block-decimation image downscaler.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | pixel_red, pixel_green, pixel_blue, frame_start
//   rsp     | out       | rsp_valid/stall    | out_red, out_green, out_blue, row_end, frame_end
//   csr     | in        | csr_valid/ready    | csr_index, csr_wdata
//
// One pixel is accepted per cycle while the queue is not full; classification happens in the accept cycle.
// A result follows its closing pixel through the queue, the line-store read stage, then the output register.
// The rate is set by the single line-store port, used once per queued operation.
// Reset is synchronous and clears counters, queue and valid flags; the store is not cleared.
// req_stall rises only when the four-entry operation queue is full.
`default_nettype none

module background_keyed_image_downscaler (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_pixel_red,
   input  wire logic [7:0]                       req_pixel_green,
   input  wire logic [7:0]                       req_pixel_blue,
   input  wire logic                             req_frame_start,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_out_red,
   output logic [7:0]                            rsp_out_green,
   output logic [7:0]                            rsp_out_blue,
   output logic                                  rsp_row_end,
   output logic                                  rsp_frame_end,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bkid_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bkid_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   bkid_pkg::op_type push_op, head;
   logic accept, push, pop, empty, full;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;

   bkid_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pixel_red   (req_pixel_red),
      .pixel_green (req_pixel_green),
      .pixel_blue  (req_pixel_blue),
      .frame_start (req_frame_start),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .push        (push),
      .op          (push_op)
   );

   bkid_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head    (head),
      .empty   (empty),
      .full    (full)
   );

   bkid_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

>>> rtl/bkid_checker.sv
// Port-level checks for the downscaler and their binding to the top level.
`default_nettype none

module bkid_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_red,
   input wire logic [7:0] rsp_out_green,
   input wire logic [7:0] rsp_out_blue,
   input wire logic       rsp_row_end,
   input wire logic       rsp_frame_end
);

   // Reset empties the queue and the output stages.
   a_reset_clears: assert property (@(posedge clock) reset |=> (!rsp_valid && !req_stall))
      else $error("outputs not idle after reset");

   // The last pixel of a frame is always also the last of its row.
   a_frame_end_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_row_end)
      else $error("frame_end without row_end");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_out_red) && $stable(rsp_out_green) &&
                                    $stable(rsp_out_blue) && $stable(rsp_row_end) &&
                                    $stable(rsp_frame_end)))
      else $error("stalled result changed");

endmodule

bind background_keyed_image_downscaler bkid_checker u_bkid_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_red   (rsp_out_red),
   .rsp_out_green (rsp_out_green),
   .rsp_out_blue  (rsp_out_blue),
   .rsp_row_end   (rsp_row_end),
   .rsp_frame_end (rsp_frame_end)
);

`default_nettype wire

>>> verif/tb_background_keyed_image_downscaler.sv
// Self-checking testbench for the background-keyed image downscaler.

typedef struct packed {
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       row_end;
   logic       frame_end;
} scaled_pixel_type;

class downscale_scoreboard;
   logic [bkid_pkg::COLOR_W-1:0] key_color;
   logic [bkid_pkg::IW_W-1:0]    in_width;
   logic [bkid_pkg::OW_W-1:0]    out_width;
   logic [bkid_pkg::OH_W-1:0]    out_height;
   logic [bkid_pkg::ACC_W-1:0]   step_x;
   logic [bkid_pkg::ACC_W-1:0]   step_y;

   logic [bkid_pkg::COL_W-1:0]   in_col;
   logic [bkid_pkg::ROW_W-1:0]   in_row;
   logic [bkid_pkg::ACC_W-1:0]   x_acc;
   logic [bkid_pkg::ACC_W-1:0]   y_acc;
   logic [bkid_pkg::OCOL_W-1:0]  out_col;
   logic [bkid_pkg::OH_W-1:0]    out_row;
   logic [bkid_pkg::COLOR_W-1:0] line_colors [bkid_pkg::MAX_OUT_WIDTH];

   scaled_pixel_type   due_pixels [$];
   int                 pixels_in;
   int                 pixels_out;
   int                 errors;

   function new();
      key_color  = 24'hFFFFFF;
      in_width   = 14'd1024;
      out_width  = 12'd512;
      out_height = 14'd512;
      step_x     = 30'h2_0000;
      step_y     = 30'h2_0000;
      restart_frame();
      foreach (line_colors[i]) line_colors[i] = '0;
      pixels_in  = 0;
      pixels_out = 0;
      errors     = 0;
   endfunction

   function void restart_frame();
      in_col  = '0;
      in_row  = '0;
      x_acc   = '0;
      y_acc   = '0;
      out_col = '0;
      out_row = '0;
   endfunction

   function void set_register(input logic [bkid_pkg::CSR_IDX_W-1:0] sel,
                              input logic [bkid_pkg::CSR_DATA_W-1:0] data);
      case (sel)
         bkid_pkg::REG_BACKGROUND:    key_color  = data[bkid_pkg::COLOR_W-1:0];
         bkid_pkg::REG_INPUT_WIDTH:   in_width   = data[bkid_pkg::IW_W-1:0];
         bkid_pkg::REG_OUTPUT_WIDTH:  out_width  = data[bkid_pkg::OW_W-1:0];
         bkid_pkg::REG_OUTPUT_HEIGHT: out_height = data[bkid_pkg::OH_W-1:0];
         bkid_pkg::REG_STEP_X:        step_x     = data[bkid_pkg::ACC_W-1:0];
         bkid_pkg::REG_STEP_Y:        step_y     = data[bkid_pkg::ACC_W-1:0];
         default: ;
      endcase
   endfunction

   // Positions clamp at the top of the 30-bit range instead of wrapping.
   function logic [bkid_pkg::ACC_W-1:0] advance(input logic [bkid_pkg::ACC_W-1:0] pos,
                                                input logic [bkid_pkg::ACC_W-1:0] step);
      int unsigned s;
      s = 32'(pos) + 32'(step);
      if (s > ((32'd1 << bkid_pkg::ACC_W) - 1)) return '1;
      return s[bkid_pkg::ACC_W-1:0];
   endfunction

   // A step below 1.0 still covers one input pixel.
   function int unsigned block_len(input logic [bkid_pkg::ACC_W-1:0] step);
      int unsigned n;
      n = 32'(step >> bkid_pkg::FRAC_BITS);
      return (n == 0) ? 1 : n;
   endfunction

   function void accept_pixel(input logic [bkid_pkg::COLOR_W-1:0] pix, input logic frame_start);
      int unsigned      iw, ow, oh, rx, ry, ys, xs;
      bit               in_frame, row_active, last_row, row_done;
      scaled_pixel_type res;
      pixels_in++;
      if (frame_start) restart_frame();
      iw = (in_width == 0) ? 1 : 32'(in_width);
      if (iw > bkid_pkg::MAX_IN_WIDTH) iw = bkid_pkg::MAX_IN_WIDTH;
      ow = (out_width > bkid_pkg::MAX_OUT_WIDTH) ? bkid_pkg::MAX_OUT_WIDTH : 32'(out_width);
      oh = 32'(out_height);
      rx = block_len(step_x);
      ry = block_len(step_y);
      ys = 32'(y_acc >> bkid_pkg::FRAC_BITS);
      in_frame   = (out_row < oh) && (in_row >= ys);
      row_active = in_frame && ((in_row - ys) < ry);
      last_row   = in_frame && ((in_row - ys) >= ry - 1);
      row_done   = in_col >= iw - 1;

      if (row_active && out_col < ow) begin
         xs = 32'(x_acc >> bkid_pkg::FRAC_BITS);
         if (in_col >= xs) begin
            // The top-left pixel always lands; later ones only when they are not the key.
            if ((in_row == ys && in_col == xs) || pix != key_color) line_colors[out_col] = pix;
            if ((in_col - xs) >= rx - 1 || row_done) begin
               if (last_row) begin
                  res.red       = line_colors[out_col][23:16];
                  res.green     = line_colors[out_col][15:8];
                  res.blue      = line_colors[out_col][7:0];
                  res.row_end   = (out_col == ow - 1);
                  res.frame_end = res.row_end && (out_row == oh - 1);
                  due_pixels.push_back(res);
               end
               x_acc   = advance(x_acc, step_x);
               out_col = out_col + 12'd1;
            end
         end
      end

      if (row_done) begin
         in_col = '0;
         if (last_row) begin
            out_row = out_row + 14'd1;
            y_acc   = advance(y_acc, step_y);
         end
         if (in_row != '1) in_row = in_row + 16'd1;
         x_acc   = '0;
         out_col = '0;
      end else begin
         in_col = in_col + 13'd1;
      end
   endfunction

   task report_mismatch(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   task check_scaled_pixel(input scaled_pixel_type got);
      scaled_pixel_type want;
      pixels_out++;
      if (due_pixels.size() == 0) begin
         report_mismatch($sformatf("output pixel %02h%02h%02h arrived with none due",
                                   got.red, got.green, got.blue));
         return;
      end
      want = due_pixels.pop_front();
      if (got.red !== want.red)
         report_mismatch($sformatf("out %0d red %02h, due %02h", pixels_out, got.red, want.red));
      if (got.green !== want.green)
         report_mismatch($sformatf("out %0d green %02h, due %02h", pixels_out, got.green,
                                   want.green));
      if (got.blue !== want.blue)
         report_mismatch($sformatf("out %0d blue %02h, due %02h", pixels_out, got.blue, want.blue));
      if (got.row_end !== want.row_end)
         report_mismatch($sformatf("out %0d row_end %b, due %b", pixels_out, got.row_end,
                                   want.row_end));
      if (got.frame_end !== want.frame_end)
         report_mismatch($sformatf("out %0d frame_end %b, due %b", pixels_out, got.frame_end,
                                   want.frame_end));
   endtask

   function int due_count();
      return due_pixels.size();
   endfunction
endclass

module tb_background_keyed_image_downscaler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 5000;
   localparam int RANDOM_PIXELS = 300;

   localparam logic [bkid_pkg::CSR_DATA_W-1:0] HALF_STEP = 30'h0_8000;
   localparam logic [bkid_pkg::CSR_DATA_W-1:0] ONE_STEP  = 30'h1_0000;
   localparam logic [bkid_pkg::CSR_DATA_W-1:0] TWO_STEP  = 30'h2_0000;
   localparam logic [bkid_pkg::CSR_DATA_W-1:0] MAX_STEP  = 30'h3FFF_FFFF;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [7:0]                      req_pixel_red;
   logic [7:0]                      req_pixel_green;
   logic [7:0]                      req_pixel_blue;
   logic                            req_frame_start;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [7:0]                      rsp_out_red;
   logic [7:0]                      rsp_out_green;
   logic [7:0]                      rsp_out_blue;
   logic                            rsp_row_end;
   logic                            rsp_frame_end;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [bkid_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bkid_pkg::CSR_DATA_W-1:0] csr_wdata;

   int                    idle_pct = 19;
   int                    phases   = 0;
   downscale_scoreboard   sb;

   background_keyed_image_downscaler u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.accept_pixel({req_pixel_red, req_pixel_green, req_pixel_blue}, req_frame_start);
         if (rsp_valid && !rsp_stall)
            sb.check_scaled_pixel({rsp_out_red, rsp_out_green, rsp_out_blue, rsp_row_end,
                                   rsp_frame_end});
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_pixel(input logic [23:0] pix, input logic frame_start);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_red   <= pix[23:16];
      req_pixel_green <= pix[15:8];
      req_pixel_blue  <= pix[7:0];
      req_frame_start <= frame_start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drain all due output, then give write-only work in the queue time to retire.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.due_count() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_scaler(input logic [bkid_pkg::CSR_DATA_W-1:0] bg,
                                 input logic [bkid_pkg::CSR_DATA_W-1:0] iw,
                                 input logic [bkid_pkg::CSR_DATA_W-1:0] ow,
                                 input logic [bkid_pkg::CSR_DATA_W-1:0] oh,
                                 input logic [bkid_pkg::CSR_DATA_W-1:0] sx,
                                 input logic [bkid_pkg::CSR_DATA_W-1:0] sy);
      logic [bkid_pkg::CSR_DATA_W-1:0] value [6];
      logic [bkid_pkg::CSR_IDX_W-1:0]  reg_sel [6];
      value   = '{bg, iw, ow, oh, sx, sy};
      reg_sel = '{bkid_pkg::REG_BACKGROUND, bkid_pkg::REG_INPUT_WIDTH,
                  bkid_pkg::REG_OUTPUT_WIDTH, bkid_pkg::REG_OUTPUT_HEIGHT,
                  bkid_pkg::REG_STEP_X, bkid_pkg::REG_STEP_Y};
      wait_idle();
      for (int i = 0; i < 6; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_sel[i];
         csr_wdata <= value[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.set_register(reg_sel[i], value[i]);
      end
      csr_valid <= 1'b0;
      phases++;
   endtask

   // The first item opens a frame. When the key must be avoided every pixel writes the line
   // store, so fractional steps never read a column entry that was never filled.
   task automatic stream_pixels(input int n, input int bg_pct, input bit avoid_key,
                                input bit noisy);
      logic [23:0] pix;
      logic [23:0] key;
      logic        frame_start;
      int          pick;
      key = sb.key_color;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < bg_pct) pix = key;
         else if (pick < bg_pct + 10) pix = key ^ (24'd1 << $urandom_range(23));
         else pix = 24'($urandom);
         if (avoid_key && pix == key) pix[0] = ~pix[0];
         frame_start = (i == 0) || (noisy && $urandom_range(99) == 0);
         if (noisy && i > 0 && $urandom_range(99) == 0) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.due_count() != 0);
         end
         send_pixel(pix, frame_start);
      end
   endtask

   // A 4x4 frame into 2x2 blocks: a kept top-left, last non-key wins, pixels after the
   // frame, and a second frame whose first block is all key.
   task automatic directed_frames();
      logic [23:0] pix [25];
      pix = '{24'h123456, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
              24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
              24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
              24'h7F0080, 24'hFFFFFF, 24'hFFFFFF, 24'h0000FF,
              24'hABCDEF, 24'h00FF00, 24'hFF00FF,
              24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
      for (int i = 0; i < 25; i++) send_pixel(pix[i], (i == 0) || (i == 19));
   endtask

   task automatic random_phase(input bit noisy);
      logic [23:0] bg;
      int unsigned iw, ow, oh, sx, sy, rows, pick;
      pick = $urandom_range(99);
      if (pick < 15) bg = 24'h000000;
      else if (pick < 30) bg = 24'hFFFFFF;
      else bg = 24'($urandom);
      iw = $urandom_range(1, 20);
      pick = $urandom_range(99);
      if (pick < 10) sx = $urandom_range(0, 16'hFFFF);
      else if (pick < 14) sx = $urandom_range(6 << 16, 40 << 16);
      else sx = $urandom_range(1 << 16, (4 << 16) - 1);
      pick = $urandom_range(99);
      if (sx == 0 || pick >= 60) begin
         ow = $urandom_range(0, iw + 3);
      end else begin
         ow = (iw << 16) / sx;
         if (ow == 0) ow = 1;
         if (ow > 4095) ow = 4095;
      end
      if (pick < 3) ow = 4095;
      pick = $urandom_range(99);
      if (pick < 10) sy = $urandom_range(0, 16'hFFFF);
      else if (pick < 15) sy = $urandom_range(5 << 16, 9 << 16);
      else sy = $urandom_range(1 << 16, (4 << 16) - 1);
      pick = $urandom_range(99);
      if (pick < 5) oh = 16383;
      else if (pick < 10) oh = 0;
      else oh = $urandom_range(1, 4);
      rows = $urandom_range(1, 9);
      program_scaler((bkid_pkg::CSR_DATA_W)'(bg), (bkid_pkg::CSR_DATA_W)'(iw),
                     (bkid_pkg::CSR_DATA_W)'(ow), (bkid_pkg::CSR_DATA_W)'(oh),
                     (bkid_pkg::CSR_DATA_W)'(sx), (bkid_pkg::CSR_DATA_W)'(sy));
      stream_pixels(int'(rows * iw), $urandom_range(0, 90), sx < (1 << 16), noisy);
   endtask

   initial begin : stimulus
      int random_start;
      sb = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_pixel_red   <= '0;
      req_pixel_green <= '0;
      req_pixel_blue  <= '0;
      req_frame_start <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= bkid_pkg::REG_BACKGROUND;
      csr_wdata       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      program_scaler(30'hFF_FFFF, 30'd4, 30'd2, 30'd2, TWO_STEP, TWO_STEP);
      directed_frames();

      // Fractional and zero steps: one output column per input column.
      program_scaler((bkid_pkg::CSR_DATA_W)'(24'($urandom)), 30'd6, 30'd9, 30'd3, HALF_STEP,
                     ONE_STEP);
      stream_pixels(24, 0, 1'b1, 1'b0);
      program_scaler(30'h00_0000, 30'd3, 30'd5, 30'd2, 30'd0, 30'd0);
      stream_pixels(9, 0, 1'b1, 1'b0);
      // Zero input width acts as a one-pixel row.
      program_scaler(30'h00_0000, 30'd0, 30'd1, 30'd4, ONE_STEP, ONE_STEP);
      stream_pixels(6, 40, 1'b0, 1'b0);
      // Oversized input and output widths, with neither side idling; the row stays open.
      idle_pct = 0;
      program_scaler(30'hFF_FFFF, 30'd16383, 30'd4095, 30'd1, 30'h4_0000, ONE_STEP);
      stream_pixels(200, 70, 1'b0, 1'b0);
      idle_pct = 19;
      // No output width, then no output height.
      program_scaler(30'h12_3456, 30'd5, 30'd0, 30'd3, ONE_STEP, ONE_STEP);
      stream_pixels(10, 30, 1'b0, 1'b0);
      program_scaler(30'h12_3456, 30'd5, 30'd3, 30'd0, ONE_STEP, ONE_STEP);
      stream_pixels(10, 30, 1'b0, 1'b0);
      // Largest horizontal step: one truncated block per row and no row end.
      program_scaler(30'h80_8080, 30'd10, 30'd3, 30'd2, MAX_STEP, 30'h2_8000);
      stream_pixels(60, 50, 1'b0, 1'b0);
      // Largest vertical step: the rows of one tall block fill the line store but close nothing.
      program_scaler((bkid_pkg::CSR_DATA_W)'(24'($urandom)), 30'd1, 30'd1, 30'd16383,
                     ONE_STEP, MAX_STEP);
      stream_pixels(120, 85, 1'b0, 1'b0);
      program_scaler(30'h00_0000, 30'd8, 30'd4, 30'd3, TWO_STEP, TWO_STEP);
      stream_pixels(48, 60, 1'b0, 1'b0);

      random_start = sb.pixels_in;
      idle_pct = 0;
      random_phase(1'b0);
      idle_pct = 19;
      while (sb.pixels_in - random_start < RANDOM_PIXELS) random_phase($urandom_range(3) == 0);
      wait_idle();

      $display("Ran %0d scaler settings: %0d pixels in, %0d output pixels checked.",
               phases, sb.pixels_in, sb.pixels_out);
      $display("Settings included fractional, zero and maximum steps and width and height limits.");
      if (sb.errors == 0 && sb.due_count() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
